FILE: rtl/dvrt_pkg.sv
// types and constants shared by the route table modules
`timescale 1ns / 1ps

package dvrt_pkg;

    localparam logic [30:0] DIST_INF       = 31'h7FFF_FFFF;
    localparam logic [3:0]  MAX_TTL        = 4'd15;
    localparam logic [7:0]  RELOAD_DEFAULT = 8'd20;
    localparam int          MAX_RESULTS    = 16;
    localparam int          EMIT_W         = $clog2(MAX_RESULTS + 1);
    localparam int          APB_AW         = 4;

    typedef enum logic [1:0] {
        CMD_ADVERT,
        CMD_TICK,
        CMD_FORWARD,
        CMD_ORIGINATE
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_ABSORB,
        ACT_LOCAL,
        ACT_DROP,
        ACT_SEND,
        ACT_BCAST,
        ACT_ENTRY
    } t_action;

    typedef enum logic [1:0] {
        REG_OWN_ADDR,
        REG_OWN_MAC,
        REG_VAL_RELOAD
    } t_reg_idx;

    typedef enum logic [1:0] {
        ALU_EQ,
        ALU_GE,
        ALU_ADD_SAT,
        ALU_DEC_SAT
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_ADDR,
        ST_CHK_MAC,
        ST_SUM,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_DECIDE,
        ST_SLOT_RD,
        ST_SLOT_EV,
        ST_SLOT_GE,
        ST_AGE_RD,
        ST_AGE_EV,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] next_hop;
        logic [30:0] distance;
        logic [7:0]  validity;
    } t_slot;

    typedef struct packed {
        t_action     action;
        logic [31:0] entry_addr;
        logic [31:0] next_hop;
        logic [30:0] route_distance;
        logic [7:0]  route_validity;
        logic [3:0]  ttl;
        logic        table_full;
        logic        last;
    } t_result;

endpackage

FILE: rtl/distance_vector_route_table.sv
// top level: sequencer, configuration registers and result register
`timescale 1ns / 1ps

// Distance-vector route table. Items enter on the in channel (valid/stall) and
// results leave through an output register on the out channel, so a finished
// result may wait there while the next item is taken. One item is worked at a
// time; o_in_stall is high from acceptance until the sequencer is back in idle.
// The cost is set by the slot walk: every slot is read from the slot memory
// and compared by the single shared unit. Advertisements (unless split horizon
// drops them), forward lookups (unless delivered locally or with a zero ttl)
// and originate lookups walk the slots once, and a tick walks them twice, a
// scan and then an aging pass; a result beat that waits for the output
// register holds the sequencer. Ticks emit valid slots in slot order, at most
// 16 beats. There is no clearing pass after reset. Registers: own_addr at 0x0,
// own_mac at 0x4, validity_reload at 0x8.
module distance_vector_route_table import dvrt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [31:0]       i_dest_addr,
    input  logic [31:0]       i_via_mac,
    input  logic [30:0]       i_adv_distance,
    input  logic [7:0]        i_adv_validity,
    input  logic [15:0]       i_link_cost,
    input  logic [3:0]        i_ttl_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_action,
    output logic [31:0]       o_entry_addr,
    output logic [31:0]       o_next_hop,
    output logic [30:0]       o_route_distance,
    output logic [7:0]        o_route_validity,
    output logic [3:0]        o_ttl_out,
    output logic              o_table_full,
    output logic              o_last
);

    localparam int            IW       = $clog2(TABLE_ENTRIES);
    localparam int            CW       = $clog2(TABLE_ENTRIES + 1);
    localparam int            LW       = (CW > EMIT_W) ? CW : EMIT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // control registers
    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_own_addr, n_own_addr;
    logic [31:0]   r_own_mac, n_own_mac;
    logic [7:0]    r_reload, n_reload;

    // item and walk registers
    t_cmd          r_cmd, n_cmd;
    logic [31:0]   r_dest, n_dest;
    logic [31:0]   r_via, n_via;
    logic [30:0]   r_dist, n_dist;
    logic [7:0]    r_val, n_val;
    logic [15:0]   r_cost, n_cost;
    logic [3:0]    r_ttl, n_ttl;
    logic          r_poison, n_poison;
    logic [30:0]   r_sum, n_sum;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    logic [IW-1:0] r_found_idx, n_found_idx;
    logic          r_free, n_free;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [CW-1:0] r_nvalid, n_nvalid;
    logic [EMIT_W-1:0] r_emit, n_emit;
    logic          r_full, n_full;
    logic          r_hop_eq, n_hop_eq;
    t_result       r_fin, n_fin;
    t_result       r_out, n_out;

    // memory and shared unit
    logic          w_rd_en;
    logic [IW-1:0] w_rd_idx;
    logic          w_rd_valid;
    t_slot         w_rd_data;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_idx;
    t_slot         w_wr_data;
    t_alu_op       w_alu_op;
    logic [31:0]   w_alu_a;
    logic [31:0]   w_alu_b;
    logic [31:0]   w_alu_res;
    logic          w_alu_flag;

    logic          w_out_free;
    logic          w_out_load;
    logic          w_step;
    logic          w_cfg_wr;
    logic [LW-1:0] w_nv_ext;
    logic [LW-1:0] w_lim;
    logic          w_tick_last;

    dvrt_slot_mem #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_rd_en),
        .i_rd_idx   (w_rd_idx),
        .o_rd_valid (w_rd_valid),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (w_wr_idx),
        .i_wr_data  (w_wr_data)
    );

    dvrt_alu u_alu (
        .i_op   (w_alu_op),
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_res  (w_alu_res),
        .o_flag (w_alu_flag)
    );

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_nv_ext    = LW'(r_nvalid);
    assign w_lim       = (w_nv_ext > LW'(MAX_RESULTS)) ? LW'(MAX_RESULTS) : w_nv_ext;
    assign w_tick_last = ((LW'(r_emit) + LW'(1)) == w_lim);

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_own_addr = r_own_addr;
        n_own_mac  = r_own_mac;
        n_reload   = r_reload;
        prdata     = '0;
        unique case (t_reg_idx'(paddr[3:2]))
            REG_OWN_ADDR: begin
                prdata = r_own_addr;
                if (w_cfg_wr) begin
                    n_own_addr = pwdata;
                end
            end
            REG_OWN_MAC: begin
                prdata = r_own_mac;
                if (w_cfg_wr) begin
                    n_own_mac = pwdata;
                end
            end
            REG_VAL_RELOAD: begin
                prdata = {24'd0, r_reload};
                if (w_cfg_wr) begin
                    n_reload = pwdata[7:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_cmd       = r_cmd;
        n_dest      = r_dest;
        n_via       = r_via;
        n_dist      = r_dist;
        n_val       = r_val;
        n_cost      = r_cost;
        n_ttl       = r_ttl;
        n_poison    = r_poison;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_nvalid    = r_nvalid;
        n_emit      = r_emit;
        n_full      = r_full;
        n_hop_eq    = r_hop_eq;
        n_fin       = r_fin;
        w_alu_op    = ALU_EQ;
        w_alu_a     = '0;
        w_alu_b     = '0;
        w_rd_en     = 1'b0;
        w_rd_idx    = r_idx;
        w_wr_en     = 1'b0;
        w_wr_idx    = r_idx;
        w_wr_data   = w_rd_data;
        w_out_load  = 1'b0;
        w_step      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = t_cmd'(i_cmd);
                    n_dest   = i_dest_addr;
                    n_via    = i_via_mac;
                    n_dist   = i_adv_distance;
                    n_val    = i_adv_validity;
                    n_cost   = i_link_cost;
                    n_ttl    = i_ttl_in;
                    n_poison = (i_adv_distance == DIST_INF);
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_free   = 1'b0;
                    n_nvalid = '0;
                    n_emit   = '0;
                    n_full   = 1'b0;
                    if (i_cmd == CMD_ADVERT || i_cmd == CMD_FORWARD) begin
                        n_state = ST_CHK_ADDR;
                    end else begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_CHK_ADDR: begin
                w_alu_op   = ALU_EQ;
                w_alu_a    = r_dest;
                w_alu_b    = r_own_addr;
                n_fin      = '0;
                n_fin.last = 1'b1;
                if (r_cmd == CMD_ADVERT) begin
                    if (w_alu_flag) begin
                        n_fin.action = ACT_ABSORB;
                        n_state      = ST_RESULT;
                    end else begin
                        n_state = ST_CHK_MAC;
                    end
                end else if (w_alu_flag) begin
                    n_fin.action = ACT_LOCAL;
                    n_state      = ST_RESULT;
                end else if (r_ttl == 4'd0) begin
                    n_fin.action = ACT_DROP;
                    n_state      = ST_RESULT;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_CHK_MAC: begin
                w_alu_op = ALU_EQ;
                w_alu_a  = r_via;
                w_alu_b  = r_own_mac;
                if (w_alu_flag) begin
                    n_fin        = '0;
                    n_fin.action = ACT_ABSORB;
                    n_fin.last   = 1'b1;
                    n_state      = ST_RESULT;
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                w_alu_op = ALU_ADD_SAT;
                w_alu_a  = {1'b0, r_dist};
                w_alu_b  = {16'd0, r_cost};
                n_sum    = w_alu_res[30:0];
                n_state  = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                w_rd_en  = 1'b1;
                w_rd_idx = r_idx;
                n_state  = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                w_alu_op = ALU_EQ;
                w_alu_a  = w_rd_data.addr;
                w_alu_b  = (r_cmd == CMD_TICK) ? r_own_addr : r_dest;
                if (w_rd_valid) begin
                    n_nvalid = r_nvalid + CW'(1);
                    if (w_alu_flag && !r_found) begin
                        n_found     = 1'b1;
                        n_found_idx = r_idx;
                    end
                end else if (!r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                n_fin      = '0;
                n_fin.last = 1'b1;
                unique case (r_cmd)
                    CMD_TICK: begin
                        w_wr_data = '{addr: r_own_addr, next_hop: r_own_mac,
                                      distance: '0, validity: r_reload};
                        if (r_found) begin
                            w_wr_en  = 1'b1;
                            w_wr_idx = r_found_idx;
                        end else if (r_free) begin
                            w_wr_en  = 1'b1;
                            w_wr_idx = r_free_idx;
                            n_nvalid = r_nvalid + CW'(1);
                        end else begin
                            n_full = 1'b1;
                        end
                        n_idx   = '0;
                        n_state = ST_AGE_RD;
                    end
                    CMD_ADVERT: begin
                        n_fin.action = ACT_ABSORB;
                        if (r_found) begin
                            n_state = ST_SLOT_RD;
                        end else if (r_poison) begin
                            n_state = ST_RESULT;
                        end else if (r_free) begin
                            w_wr_en   = 1'b1;
                            w_wr_idx  = r_free_idx;
                            w_wr_data = '{addr: r_dest, next_hop: r_via,
                                          distance: r_sum, validity: r_val};
                            n_state   = ST_RESULT;
                        end else begin
                            n_fin.table_full = 1'b1;
                            n_state          = ST_RESULT;
                        end
                    end
                    CMD_FORWARD: begin
                        if (r_found) begin
                            n_state = ST_SLOT_RD;
                        end else begin
                            n_fin.action = ACT_BCAST;
                            n_fin.ttl    = r_ttl - 4'd1;
                            n_state      = ST_RESULT;
                        end
                    end
                    CMD_ORIGINATE: begin
                        if (r_found) begin
                            n_state = ST_SLOT_RD;
                        end else begin
                            n_fin.action = ACT_BCAST;
                            n_fin.ttl    = MAX_TTL;
                            n_state      = ST_RESULT;
                        end
                    end
                endcase
            end
            ST_SLOT_RD: begin
                w_rd_en  = 1'b1;
                w_rd_idx = r_found_idx;
                n_state  = ST_SLOT_EV;
            end
            ST_SLOT_EV: begin
                n_fin      = '0;
                n_fin.last = 1'b1;
                unique case (r_cmd)
                    CMD_ADVERT: begin
                        w_alu_op = ALU_EQ;
                        w_alu_a  = w_rd_data.next_hop;
                        w_alu_b  = r_via;
                        n_hop_eq = w_alu_flag;
                        n_state  = ST_SLOT_GE;
                    end
                    CMD_FORWARD: begin
                        n_fin.action   = ACT_SEND;
                        n_fin.next_hop = w_rd_data.next_hop;
                        n_fin.ttl      = r_ttl - 4'd1;
                        n_state        = ST_RESULT;
                    end
                    CMD_ORIGINATE: begin
                        w_alu_op = ALU_EQ;
                        w_alu_a  = {1'b0, w_rd_data.distance};
                        w_alu_b  = {1'b0, DIST_INF};
                        if (w_alu_flag) begin
                            n_fin.action = ACT_DROP;
                        end else begin
                            n_fin.action   = ACT_SEND;
                            n_fin.next_hop = w_rd_data.next_hop;
                            n_fin.ttl      = MAX_TTL;
                        end
                        n_state = ST_RESULT;
                    end
                    CMD_TICK: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SLOT_GE: begin
                w_alu_op = ALU_GE;
                w_alu_a  = {1'b0, w_rd_data.distance};
                w_alu_b  = {1'b0, r_sum};
                w_wr_idx = r_found_idx;
                if (r_poison) begin
                    if (r_hop_eq) begin
                        w_wr_en            = 1'b1;
                        w_wr_data.distance = DIST_INF;
                        w_wr_data.validity = r_val;
                    end
                end else if (w_alu_flag) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = '{addr: r_dest, next_hop: r_via,
                                  distance: r_sum, validity: r_val};
                end else if (r_hop_eq) begin
                    w_wr_en            = 1'b1;
                    w_wr_data.validity = r_val;
                end
                n_fin        = '0;
                n_fin.action = ACT_ABSORB;
                n_fin.last   = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_AGE_RD: begin
                w_rd_en  = 1'b1;
                w_rd_idx = r_idx;
                n_state  = ST_AGE_EV;
            end
            ST_AGE_EV: begin
                w_alu_op           = ALU_DEC_SAT;
                w_alu_a            = {24'd0, w_rd_data.validity};
                w_wr_idx           = r_idx;
                w_wr_data.validity = w_alu_res[7:0];
                if (w_alu_res[7:0] == 8'd0) begin
                    w_wr_data.distance = DIST_INF;
                end
                w_step = 1'b1;
                if (w_rd_valid) begin
                    if (r_emit < EMIT_W'(MAX_RESULTS)) begin
                        if (w_out_free) begin
                            w_out_load           = 1'b1;
                            n_out                = '0;
                            n_out.action         = ACT_ENTRY;
                            n_out.entry_addr     = w_rd_data.addr;
                            n_out.next_hop       = r_own_mac;
                            n_out.route_distance = w_wr_data.distance;
                            n_out.route_validity = w_wr_data.validity;
                            n_out.table_full     = r_full;
                            n_out.last           = w_tick_last;
                            n_emit               = r_emit + EMIT_W'(1);
                        end else begin
                            w_step = 1'b0;
                        end
                    end
                    w_wr_en = w_step;
                end
                if (w_step) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_AGE_RD;
                    end
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_out      = r_fin;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_own_addr  <= '0;
            r_own_mac   <= '0;
            r_reload    <= RELOAD_DEFAULT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_own_addr  <= n_own_addr;
            r_own_mac   <= n_own_mac;
            r_reload    <= n_reload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_dest      <= n_dest;
        r_via       <= n_via;
        r_dist      <= n_dist;
        r_val       <= n_val;
        r_cost      <= n_cost;
        r_ttl       <= n_ttl;
        r_poison    <= n_poison;
        r_sum       <= n_sum;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_nvalid    <= n_nvalid;
        r_emit      <= n_emit;
        r_full      <= n_full;
        r_hop_eq    <= n_hop_eq;
        r_fin       <= n_fin;
        r_out       <= n_out;
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_action         = r_out.action;
    assign o_entry_addr     = r_out.entry_addr;
    assign o_next_hop       = r_out.next_hop;
    assign o_route_distance = r_out.route_distance;
    assign o_route_validity = r_out.route_validity;
    assign o_ttl_out        = r_out.ttl;
    assign o_table_full     = r_out.table_full;
    assign o_last           = r_out.last;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start the sequencer");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && w_out_load) |=> (r_state == ST_IDLE))
        else $error("result beat loaded while sequencer still busy");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_wr_en)
        else $error("slot memory written while idle");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AGE_EV) |-> (r_emit <= EMIT_W'(MAX_RESULTS)))
        else $error("tick emitted too many entry beats");
`endif

endmodule

FILE: rtl/dvrt_alu.sv
// shared compare, saturating add and saturating decrement unit
`timescale 1ns / 1ps

module dvrt_alu import dvrt_pkg::*; (
    input  t_alu_op     i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res,
    output logic        o_flag
);

    logic [31:0] w_sum;

    assign w_sum = {1'b0, i_a[30:0]} + {1'b0, i_b[30:0]};

    always_comb begin
        o_res  = '0;
        o_flag = 1'b0;
        unique case (i_op)
            ALU_EQ: begin
                o_flag = (i_a == i_b);
            end
            ALU_GE: begin
                o_flag = (i_a >= i_b);
            end
            ALU_ADD_SAT: begin
                if (w_sum > {1'b0, DIST_INF}) begin
                    o_res = {1'b0, DIST_INF};
                end else begin
                    o_res = w_sum;
                end
            end
            ALU_DEC_SAT: begin
                o_res = (i_a == '0) ? '0 : (i_a - 32'd1);
            end
        endcase
    end

endmodule

FILE: rtl/dvrt_slot_mem.sv
// route slot memory with registered read and per-slot valid bits
`timescale 1ns / 1ps

module dvrt_slot_mem import dvrt_pkg::*; #(
    parameter  int ENTRIES = 16,
    localparam int IW      = $clog2(ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_idx,
    output logic          o_rd_valid,
    output t_slot         o_rd_data,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_idx,
    input  t_slot         i_wr_data
);

    t_slot              r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_slot              r_rd_data;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx];
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule
